/* hdl/cfa_pkg.sv */
// Shared widths, codes and control types for the clamped force accumulator.
`default_nettype none
package cfa_pkg;

	localparam int FORCE_W  = 16;
	localparam int WEIGHT_W = 12;
	localparam int MAXF_W   = 15;
	localparam logic [MAXF_W-1:0] MAXF_RESET = 15'd32767;

	typedef enum logic [2:0] {
		MUL_FXW,
		MUL_FYW,
		MUL_RX,
		MUL_RY,
		MUL_SX,
		MUL_SY,
		MUL_SXR,
		MUL_SYR
	} cfa_mul_sel_t;

	typedef struct packed {
		logic         load_in;
		logic         mul_en;
		cfa_mul_sel_t mul_sel;
		logic         sx_load;
		logic         sy_load;
		logic         acc_load;
		logic         sqrt_start;
		logic         rem_load;
		logic         madd_load;
		logic         add_whole;
		logic         div_start;
		logic         add_qx;
		logic         add_qy;
		logic         set_stop;
		logic         emit;
	} cfa_cmd_t;

	typedef struct packed {
		logic stopped;
		logic last;
		logic rem_le0;
		logic madd_lt_rem;
		logic sqrt_done;
		logic div_done;
	} cfa_sts_t;

endpackage
`default_nettype wire

/* hdl/cfa_ifs.sv */
// Channel interfaces: input items, results and the max_force write port.
`default_nettype none
interface cfa_item_if;
	import cfa_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [FORCE_W-1:0]  force_x;
	logic signed [FORCE_W-1:0]  force_y;
	logic        [WEIGHT_W-1:0] weight;
	logic                       last;
	modport source (output valid, force_x, force_y, weight, last, input ready);
	modport sink (input valid, force_x, force_y, weight, last, output ready);
endinterface

interface cfa_result_if;
	import cfa_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [FORCE_W-1:0] total_x;
	logic signed [FORCE_W-1:0] total_y;
	logic                      budget_exhausted;
	modport source (output valid, total_x, total_y, budget_exhausted, input ready);
	modport sink (input valid, total_x, total_y, budget_exhausted, output ready);
endinterface

interface cfa_cfg_if;
	import cfa_pkg::*;
	logic              valid;
	logic              ready;
	logic [MAXF_W-1:0] max_force;
	modport source (output valid, max_force, input ready);
	modport sink (input valid, max_force, output ready);
endinterface
`default_nettype wire

/* hdl/cfa_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module cfa_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [15:0] root
);
	logic [31:0] rad_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [19:0] rem_sh;
	logic [19:0] trial;
	logic [19:0] rem_d;
	logic [15:0] root_d;

	always_comb begin
		rem_sh = {rem_q, rad_q[31:30]};
		trial  = {2'b00, root_q, 2'b01};
		if (rem_sh >= trial) begin
			rem_d  = rem_sh - trial;
			root_d = {root_q[14:0], 1'b1};
		end else begin
			rem_d  = rem_sh;
			root_d = {root_q[14:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[29:0], 2'b00};
			rem_q  <= rem_d[17:0];
			root_q <= root_d;
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

/* hdl/cfa_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module cfa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [29:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quotient
);
	logic [29:0] dvd_q;
	logic [15:0] dvs_q;
	logic [15:0] r_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [16:0] r_sh;
	logic [16:0] r_d;
	logic        qbit;

	always_comb begin
		r_sh = {r_q, dvd_q[29]};
		if (r_sh >= {1'b0, dvs_q}) begin
			r_d  = r_sh - {1'b0, dvs_q};
			qbit = 1'b1;
		end else begin
			r_d  = r_sh;
			qbit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd29) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The quotient bits shift in behind the dividend bits as they are used up.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[28:0], qbit};
			r_q   <= r_d[15:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q[15:0];
endmodule
`default_nettype wire

/* hdl/cfa_dp.sv */
// Datapath: input capture, shared multiplier, running total, root and divide units.
`default_nettype none
module cfa_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [cfa_pkg::FORCE_W-1:0] force_x,
	input  logic signed [cfa_pkg::FORCE_W-1:0] force_y,
	input  logic        [cfa_pkg::WEIGHT_W-1:0] weight,
	input  logic                               last,
	input  logic                               cfg_we,
	input  logic        [cfa_pkg::MAXF_W-1:0]  cfg_max_force,
	input  cfa_pkg::cfa_cmd_t                  cmd,
	output cfa_pkg::cfa_sts_t                  sts,
	output logic signed [cfa_pkg::FORCE_W-1:0] total_x,
	output logic signed [cfa_pkg::FORCE_W-1:0] total_y,
	output logic                               budget_exhausted
);
	import cfa_pkg::*;

	localparam logic signed [35:0] SAT_HI = 36'sd32767;
	localparam logic signed [35:0] SAT_LO = -36'sd32768;

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v > SAT_HI) r = 16'sh7FFF;
		else if (v < SAT_LO) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
	                                               input logic signed [16:0] b);
		logic signed [17:0] s;
		s = {{2{a[15]}}, a} + {b[16], b};
		return sat16({{18{s[17]}}, s});
	endfunction

	logic [MAXF_W-1:0]    max_force_q;
	logic signed [15:0]   run_x_q, run_y_q;
	logic                 stopped_q;
	logic signed [15:0]   fx_q, fy_q, sx_q, sy_q;
	logic [WEIGHT_W-1:0]  w_q;
	logic                 last_q;
	logic signed [35:0]   prod_q;
	logic [31:0]          acc_q;
	logic signed [17:0]   rem_q;
	logic [15:0]          madd_q;
	logic signed [15:0]   tot_x_q, tot_y_q;
	logic                 exh_q;

	logic signed [17:0]   mul_a, mul_b;
	logic signed [35:0]   mul_p;
	logic signed [35:0]   prod_abs;
	logic [15:0]          sq_root;
	logic                 sq_done;
	logic [15:0]          quo;
	logic                 dv_done;
	logic signed [16:0]   qx, qy;

	always_comb begin
		case (cmd.mul_sel)
			MUL_FXW: begin
				mul_a = {{2{fx_q[15]}}, fx_q};
				mul_b = {6'b0, w_q};
			end
			MUL_FYW: begin
				mul_a = {{2{fy_q[15]}}, fy_q};
				mul_b = {6'b0, w_q};
			end
			MUL_RX: begin
				mul_a = {{2{run_x_q[15]}}, run_x_q};
				mul_b = mul_a;
			end
			MUL_RY: begin
				mul_a = {{2{run_y_q[15]}}, run_y_q};
				mul_b = mul_a;
			end
			MUL_SX: begin
				mul_a = {{2{sx_q[15]}}, sx_q};
				mul_b = mul_a;
			end
			MUL_SY: begin
				mul_a = {{2{sy_q[15]}}, sy_q};
				mul_b = mul_a;
			end
			MUL_SXR: begin
				mul_a = {{2{sx_q[15]}}, sx_q};
				mul_b = rem_q;
			end
			MUL_SYR: begin
				mul_a = {{2{sy_q[15]}}, sy_q};
				mul_b = rem_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_abs = prod_q[35] ? -prod_q : prod_q;

	cfa_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (acc_q + prod_q[31:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

	cfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_abs[29:0]),
		.divisor  (madd_q),
		.done     (dv_done),
		.quotient (quo)
	);

	// The remaining budget is positive here, so the quotient takes the sign of the force.
	assign qx = sx_q[15] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign qy = sy_q[15] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			fx_q   <= force_x;
			fy_q   <= force_y;
			w_q    <= weight;
			last_q <= last;
		end
		if (cmd.mul_en) prod_q <= mul_p;
		if (cmd.sx_load) sx_q <= sat16(prod_q >>> 8);
		if (cmd.sy_load) sy_q <= sat16(prod_q >>> 8);
		if (cmd.acc_load) acc_q <= prod_q[31:0];
		if (cmd.rem_load) rem_q <= $signed({3'b000, max_force_q}) - $signed({2'b00, sq_root});
		if (cmd.madd_load) madd_q <= sq_root;
		if (cmd.emit) begin
			tot_x_q <= run_x_q;
			tot_y_q <= run_y_q;
			exh_q   <= stopped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_force_q <= MAXF_RESET;
			run_x_q     <= '0;
			run_y_q     <= '0;
			stopped_q   <= 1'b0;
		end else begin
			if (cfg_we) max_force_q <= cfg_max_force;
			if (cmd.emit) begin
				run_x_q   <= '0;
				run_y_q   <= '0;
				stopped_q <= 1'b0;
			end else begin
				if (cmd.add_whole) begin
					run_x_q <= add_sat(run_x_q, {sx_q[15], sx_q});
					run_y_q <= add_sat(run_y_q, {sy_q[15], sy_q});
				end
				if (cmd.add_qx) run_x_q <= add_sat(run_x_q, qx);
				if (cmd.add_qy) run_y_q <= add_sat(run_y_q, qy);
				if (cmd.set_stop) stopped_q <= 1'b1;
			end
		end
	end

	always_comb begin
		sts.stopped     = stopped_q;
		sts.last        = last_q;
		sts.rem_le0     = rem_q[17] || (rem_q == '0);
		sts.madd_lt_rem = $signed({2'b00, madd_q}) < rem_q;
		sts.sqrt_done   = sq_done;
		sts.div_done    = dv_done;
	end

	assign total_x          = tot_x_q;
	assign total_y          = tot_y_q;
	assign budget_exhausted = exh_q;
endmodule
`default_nettype wire

/* hdl/cfa_ctrl.sv */
// Controller: sequences one item through scaling, both roots and the shortening divides.
`default_nettype none
module cfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	output cfa_pkg::cfa_cmd_t cmd,
	input  cfa_pkg::cfa_sts_t sts
);
	import cfa_pkg::*;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_SCX    = 5'd1;
	localparam logic [4:0] ST_SCY    = 5'd2;
	localparam logic [4:0] ST_RX     = 5'd3;
	localparam logic [4:0] ST_RY     = 5'd4;
	localparam logic [4:0] ST_RSUM   = 5'd5;
	localparam logic [4:0] ST_RSQRT  = 5'd6;
	localparam logic [4:0] ST_REMCHK = 5'd7;
	localparam logic [4:0] ST_SX     = 5'd8;
	localparam logic [4:0] ST_SY     = 5'd9;
	localparam logic [4:0] ST_SSUM   = 5'd10;
	localparam logic [4:0] ST_SSQRT  = 5'd11;
	localparam logic [4:0] ST_CMP    = 5'd12;
	localparam logic [4:0] ST_MULX   = 5'd13;
	localparam logic [4:0] ST_DVX0   = 5'd14;
	localparam logic [4:0] ST_DVX1   = 5'd15;
	localparam logic [4:0] ST_MULY   = 5'd16;
	localparam logic [4:0] ST_DVY0   = 5'd17;
	localparam logic [4:0] ST_DVY1   = 5'd18;
	localparam logic [4:0] ST_FINISH = 5'd19;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_FXW;
		state_d     = state_q;
		item_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load_in = 1'b1;
					state_d     = sts.stopped ? ST_FINISH : ST_SCX;
				end
			end
			ST_SCX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FXW;
				state_d     = ST_SCY;
			end
			ST_SCY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FYW;
				cmd.sx_load = 1'b1;
				state_d     = ST_RX;
			end
			ST_RX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RX;
				cmd.sy_load = 1'b1;
				state_d     = ST_RY;
			end
			ST_RY: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_RY;
				cmd.acc_load = 1'b1;
				state_d      = ST_RSUM;
			end
			ST_RSUM: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_RSQRT;
			end
			ST_RSQRT: begin
				if (sts.sqrt_done) begin
					cmd.rem_load = 1'b1;
					state_d      = ST_REMCHK;
				end
			end
			ST_REMCHK: begin
				if (sts.rem_le0) begin
					cmd.set_stop = 1'b1;
					state_d      = ST_FINISH;
				end else begin
					state_d = ST_SX;
				end
			end
			ST_SX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SX;
				state_d     = ST_SY;
			end
			ST_SY: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_SY;
				cmd.acc_load = 1'b1;
				state_d      = ST_SSUM;
			end
			ST_SSUM: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_SSQRT;
			end
			ST_SSQRT: begin
				if (sts.sqrt_done) begin
					cmd.madd_load = 1'b1;
					state_d       = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.madd_lt_rem) begin
					cmd.add_whole = 1'b1;
					state_d       = ST_FINISH;
				end else begin
					state_d = ST_MULX;
				end
			end
			ST_MULX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SXR;
				state_d     = ST_DVX0;
			end
			ST_DVX0: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DVX1;
			end
			ST_DVX1: begin
				if (sts.div_done) begin
					cmd.add_qx = 1'b1;
					state_d    = ST_MULY;
				end
			end
			ST_MULY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SYR;
				state_d     = ST_DVY0;
			end
			ST_DVY0: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DVY1;
			end
			ST_DVY1: begin
				if (sts.div_done) begin
					cmd.add_qy   = 1'b1;
					cmd.set_stop = 1'b1;
					state_d      = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// A frame result waits here only while the previous one is still unread.
				if (!sts.last) begin
					state_d = ST_IDLE;
				end else if (!out_valid_q || result_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
endmodule
`default_nettype wire

/* hdl/clamped_force_accumulator.sv */
// Top level of the clamped force accumulator.
// One item is taken at a time. The work for an item depends on its path: an item that arrives
// after the budget is spent goes straight to the finish state; an item found over budget stops
// after the first square root; an item added whole takes both square roots; a shortened item
// also takes the two restoring divides. Both square roots run in the shared root unit. The
// frame result is held in an output register, so the next item is accepted while it waits to
// be read; only a second frame result stalls until the first one has been taken.
// Writes to max_force are always accepted and must be made while the block is idle.
`default_nettype none
module clamped_force_accumulator (
	input  logic          clk,
	input  logic          arst_n,
	cfa_item_if.sink      item,
	cfa_result_if.source  result,
	cfa_cfg_if.sink       cfg
);
	import cfa_pkg::*;

	cfa_cmd_t cmd;
	cfa_sts_t sts;

	assign cfg.ready = 1'b1;

	cfa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	cfa_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.force_x          (item.force_x),
		.force_y          (item.force_y),
		.weight           (item.weight),
		.last             (item.last),
		.cfg_we           (cfg.valid),
		.cfg_max_force    (cfg.max_force),
		.cmd              (cmd),
		.sts              (sts),
		.total_x          (result.total_x),
		.total_y          (result.total_y),
		.budget_exhausted (result.budget_exhausted)
	);
endmodule
`default_nettype wire

/* hdl/cfa_checker.sv */
// Port-level checks for the clamped force accumulator and their binding to the top level.
`default_nettype none
module cfa_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic signed [cfa_pkg::FORCE_W-1:0] total_x,
	input logic signed [cfa_pkg::FORCE_W-1:0] total_y,
	input logic                               budget_exhausted
);
	// Every accepted beat is followed in the next cycle by item ready low, as the block is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item ready stayed high after an accepted beat");

	// A new result appears only as the block finishes an item and turns ready again.
	a_result_with_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready)
		else $error("result appeared while an item was still in progress");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(total_x) && $stable(total_y) && $stable(budget_exhausted))
		else $error("stalled result beat changed");
endmodule

bind clamped_force_accumulator cfa_checker u_cfa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.total_x          (result.total_x),
	.total_y          (result.total_y),
	.budget_exhausted (result.budget_exhausted)
);
`default_nettype wire
